FILE: rtl/three_wire_rtc_serial_master_macros.svh
// Assertion macros shared by the three-wire serial master RTL.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TW_RTC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tw_rtc assertion failed");

// Same check with a caller-supplied message.
`define TW_RTC_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

`else

`define TW_RTC_ASSERT(lbl, clk, rstn, prop)
`define TW_RTC_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

FILE: rtl/tw_rtc_pkg.sv
// Package: types and constants of the three-wire serial master.
package tw_rtc_pkg;

  // Delay units spent before the command byte of a write.
  localparam logic [3:0] SETUP_UNITS = 4'd4;

  localparam int unsigned TpuWidth = 10;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_WPRE  = 3'd2,
    PH_WSET  = 3'd3,
    PH_WHIGH = 3'd4,
    PH_RPRE  = 3'd5,
    PH_RHIGH = 3'd6,
    PH_RLOW  = 3'd7
  } phase_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // Pin levels and status produced by one tick.
  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_pin_out;
    logic       data_drive_enable;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
  } result_t;

endpackage

FILE: rtl/tw_rtc_seq.sv
// Pin sequencer: transaction state and next-tick logic of the serial master.
`include "three_wire_rtc_serial_master_macros.svh"

module tw_rtc_seq import tw_rtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [TpuWidth-1:0] cfg_wr_data_i,
  input  logic                accept_i,
  input  logic                start_req_i,
  input  logic                opcode_i,
  input  logic [7:0]          command_i,
  input  logic [7:0]          write_data_i,
  input  logic                data_pin_in_i,
  output result_t             res_o
);

  phase_e              phase_q, phase_d;
  logic [2:0]          bit_q, bit_d;
  logic [TpuWidth-1:0] cnt_q, cnt_d;
  logic [3:0]          unit_q, unit_d;
  logic [7:0]          shift_out_q, shift_out_d;
  logic [7:0]          second_byte_q, second_byte_d;
  logic                is_read_q, is_read_d;
  logic                second_q, second_d;
  logic [7:0]          shift_in_q, shift_in_d;
  logic [7:0]          read_result_q, read_result_d;
  logic                ce_q, ce_d;
  logic                sclk_q, sclk_d;
  logic                dat_q, dat_d;
  logic                drv_q, drv_d;
  logic [TpuWidth-1:0] tpu_q;

  logic [TpuWidth-1:0] tpu_eff;
  logic [TpuWidth:0]   cnt_inc;
  logic                unit_end;
  logic                done;
  logic [2:0]          bit_nx;

  // A unit length of zero behaves as one tick.
  assign tpu_eff  = (tpu_q == '0) ? TpuWidth'(1) : tpu_q;
  assign cnt_inc  = {1'b0, cnt_q} + (TpuWidth+1)'(1);
  assign unit_end = (cnt_inc >= {1'b0, tpu_eff});
  assign bit_nx   = bit_q + 3'd1;

  always_comb begin
    phase_d       = phase_q;
    bit_d         = bit_q;
    cnt_d         = cnt_q;
    unit_d        = unit_q;
    shift_out_d   = shift_out_q;
    second_byte_d = second_byte_q;
    is_read_d     = is_read_q;
    second_d      = second_q;
    shift_in_d    = shift_in_q;
    read_result_d = read_result_q;
    ce_d          = ce_q;
    sclk_d        = sclk_q;
    dat_d         = dat_q;
    drv_d         = drv_q;
    done          = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (start_req_i) begin
        is_read_d     = opcode_i;
        shift_out_d   = command_i;
        second_byte_d = write_data_i;
        second_d      = 1'b0;
        bit_d         = 3'd0;
        ce_d          = 1'b1;
        sclk_d        = 1'b0;
        cnt_d         = '0;
        if ((opcode_i == OP_WRITE) && (SETUP_UNITS != 4'd0)) begin
          phase_d = PH_SETUP;
          unit_d  = SETUP_UNITS;
        end else begin
          drv_d   = 1'b1;
          phase_d = PH_WPRE;
          unit_d  = 4'd1;
        end
      end
    end else if (!unit_end) begin
      cnt_d = cnt_inc[TpuWidth-1:0];
    end else begin
      cnt_d = '0;
      if (unit_q > 4'd1) begin
        unit_d = unit_q - 4'd1;
      end else begin
        // Current wait is over: take the next step of the sequence.
        unit_d = 4'd1;
        case (phase_q)
          PH_SETUP: begin
            bit_d   = 3'd0;
            drv_d   = 1'b1;
            sclk_d  = 1'b0;
            phase_d = PH_WPRE;
          end
          PH_WPRE: begin
            dat_d   = shift_out_q[bit_q];
            phase_d = PH_WSET;
          end
          PH_WSET: begin
            sclk_d  = 1'b1;
            phase_d = PH_WHIGH;
          end
          PH_WHIGH: begin
            sclk_d = 1'b0;
            if (bit_q == 3'd7) begin
              bit_d = 3'd0;
              if (second_q) begin
                sclk_d  = 1'b1;
                ce_d    = 1'b0;
                phase_d = PH_IDLE;
                unit_d  = 4'd0;
                done    = 1'b1;
              end else if (is_read_q) begin
                second_d   = 1'b1;
                drv_d      = 1'b0;
                shift_in_d = 8'd0;
                phase_d    = PH_RPRE;
              end else begin
                second_d    = 1'b1;
                shift_out_d = second_byte_q;
                drv_d       = 1'b1;
                phase_d     = PH_WPRE;
              end
            end else begin
              bit_d   = bit_nx;
              dat_d   = shift_out_q[bit_nx];
              phase_d = PH_WSET;
            end
          end
          PH_RPRE: begin
            shift_in_d[bit_q] = data_pin_in_i;
            sclk_d            = 1'b1;
            phase_d           = PH_RHIGH;
          end
          PH_RHIGH: begin
            sclk_d  = 1'b0;
            phase_d = PH_RLOW;
          end
          PH_RLOW: begin
            if (bit_q == 3'd7) begin
              bit_d         = 3'd0;
              read_result_d = shift_in_q;
              sclk_d        = 1'b1;
              ce_d          = 1'b0;
              phase_d       = PH_IDLE;
              unit_d        = 4'd0;
              done          = 1'b1;
            end else begin
              bit_d              = bit_nx;
              shift_in_d[bit_nx] = data_pin_in_i;
              sclk_d             = 1'b1;
              phase_d            = PH_RHIGH;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.chip_enable       = ce_d;
    res_o.serial_clock      = sclk_d;
    res_o.data_pin_out      = dat_d;
    res_o.data_drive_enable = drv_d;
    res_o.busy              = (phase_d != PH_IDLE);
    res_o.done              = done;
    res_o.read_byte         = read_result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= TpuWidth'(1);
    end else if (cfg_wr_en_i) begin
      tpu_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_q         <= '0;
      cnt_q         <= '0;
      unit_q        <= '0;
      shift_out_q   <= '0;
      second_byte_q <= '0;
      is_read_q     <= 1'b0;
      second_q      <= 1'b0;
      shift_in_q    <= '0;
      read_result_q <= '0;
      ce_q          <= 1'b0;
      sclk_q        <= 1'b0;
      dat_q         <= 1'b0;
      drv_q         <= 1'b0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      bit_q         <= bit_d;
      cnt_q         <= cnt_d;
      unit_q        <= unit_d;
      shift_out_q   <= shift_out_d;
      second_byte_q <= second_byte_d;
      is_read_q     <= is_read_d;
      second_q      <= second_d;
      shift_in_q    <= shift_in_d;
      read_result_q <= read_result_d;
      ce_q          <= ce_d;
      sclk_q        <= sclk_d;
      dat_q         <= dat_d;
      drv_q         <= drv_d;
    end
  end

  `TW_RTC_ASSERT(a_idle_holds, clk_i, rst_ni,
    accept_i && (phase_q == PH_IDLE) && !start_req_i |=> (phase_q == PH_IDLE))
  `TW_RTC_ASSERT(a_ce_tracks_busy, clk_i, rst_ni, ce_q == (phase_q != PH_IDLE))
  `TW_RTC_ASSERT_MSG(a_wait_nonzero, clk_i, rst_ni,
    (phase_q != PH_IDLE) |-> (unit_q != 4'd0), "busy with an empty wait count")

endmodule

FILE: rtl/tw_rtc_out_reg.sv
// Result register between the sequencer and the output channel.
module tw_rtc_out_reg import tw_rtc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    take_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Load a new result, or drop the one that was just taken.
  assign valid_d = load_i | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/three_wire_rtc_serial_master.sv
// Top level of the three-wire LSB-first serial master for a clock chip.
//
// Every transfer on the input channel is one tick of the pin sequencer. A
// start request taken while idle raises chip enable with the clock low;
// writes wait the setup delay, then shift command and data bytes out LSB
// first, reads shift the command out, release the data line and sample
// eight bits. Each transaction ends with the clock high and chip enable low.
// Every input transfer yields exactly one output transfer carrying the pin
// levels after that tick, busy, a one-tick done flag and the last read byte.
// Output valid rises in the cycle after the input transfer; throughput is
// one transfer per cycle while the receiver does not stall, set by the
// single register stage after the sequencer's next-tick logic.
// The unit length register (ticks per delay unit, zero acts as one) is
// written through cfg_wr_en_i / cfg_wr_data_i and resets to one.
// Reset puts the sequencer idle, all pins low, data line released, read
// byte zero, and empties the result register.
// While the receiver stalls with a result waiting, in_stall_o is raised and
// the sequencer holds; a result being taken frees the stage in that cycle.
`include "three_wire_rtc_serial_master_macros.svh"

module three_wire_rtc_serial_master import tw_rtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [TpuWidth-1:0] cfg_wr_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                start_req_i,
  input  logic                opcode_i,
  input  logic [7:0]          command_i,
  input  logic [7:0]          write_data_i,
  input  logic                data_pin_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                chip_enable_o,
  output logic                serial_clock_o,
  output logic                data_pin_out_o,
  output logic                data_drive_enable_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          read_byte_o
);

  logic    in_accept;
  logic    out_take;
  result_t res_next;
  result_t res_out;

  // Stall only when a result is waiting and the receiver holds it.
  assign in_stall_o = out_valid_o & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_o & ~out_stall_i;

  tw_rtc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .accept_i      (in_accept),
    .start_req_i   (start_req_i),
    .opcode_i      (opcode_i),
    .command_i     (command_i),
    .write_data_i  (write_data_i),
    .data_pin_in_i (data_pin_in_i),
    .res_o         (res_next)
  );

  tw_rtc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .res_i   (res_next),
    .take_i  (out_take),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign chip_enable_o       = res_out.chip_enable;
  assign serial_clock_o      = res_out.serial_clock;
  assign data_pin_out_o      = res_out.data_pin_out;
  assign data_drive_enable_o = res_out.data_drive_enable;
  assign busy_res_o          = res_out.busy;
  assign done_res_o          = res_out.done;
  assign read_byte_o         = res_out.read_byte;

  `TW_RTC_ASSERT(a_stall_needs_result, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  `TW_RTC_ASSERT(a_transfer_gives_result, clk_i, rst_ni, in_accept |=> out_valid_o)
  `TW_RTC_ASSERT_MSG(a_no_invented_result, clk_i, rst_ni,
    !out_valid_o && !in_valid_i |=> !out_valid_o, "result without input transfer")

endmodule

FILE: sim/three_wire_rtc_serial_master_tb.sv
// Self-checking testbench for the three-wire LSB-first serial master.
`timescale 1ns / 100ps

module three_wire_rtc_serial_master_tb import tw_rtc_pkg::*; ();

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 10;
  // Longest receiver hold-off; the block must fill up and stall its input.
  localparam int unsigned HOLD_CYCLES    = 400;
  // Cycles without any transfer on either channel before giving up.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 60;

  // Clock, reset and DUT ports. Give every input a known level from time zero.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_wr_en_i   = 1'b0;
  logic [TpuWidth-1:0] cfg_wr_data_i = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                start_req_i   = 1'b0;
  logic                opcode_i      = OP_WRITE;
  logic [7:0]          command_i     = '0;
  logic [7:0]          write_data_i  = '0;
  logic                data_pin_in_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                chip_enable_o;
  logic                serial_clock_o;
  logic                data_pin_out_o;
  logic                data_drive_enable_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [7:0]          read_byte_o;

  three_wire_rtc_serial_master dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_wr_en_i         (cfg_wr_en_i),
    .cfg_wr_data_i       (cfg_wr_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .start_req_i         (start_req_i),
    .opcode_i            (opcode_i),
    .command_i           (command_i),
    .write_data_i        (write_data_i),
    .data_pin_in_i       (data_pin_in_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .chip_enable_o       (chip_enable_o),
    .serial_clock_o      (serial_clock_o),
    .data_pin_out_o      (data_pin_out_o),
    .data_drive_enable_o (data_drive_enable_o),
    .busy_res_o          (busy_res_o),
    .done_res_o          (done_res_o),
    .read_byte_o         (read_byte_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pin sequencer predictor. Each accepted input transfer is one tick; the
  // pin levels after that tick are queued as the expected output transfer.
  // ---------------------------------------------------------------------------
  phase_e              seq_phase  = PH_IDLE;
  logic [3:0]          bit_pos    = '0;   // bit of the byte in flight
  logic [11:0]         unit_ticks = '0;   // ticks elapsed in the current unit
  logic [3:0]          units_left = '0;   // units left in the current wait
  logic [7:0]          tx_shift   = '0;   // byte being shifted out
  logic [7:0]          data_byte  = '0;   // data byte latched for writes
  logic [7:0]          rx_shift   = '0;   // bits collected by a read
  logic [7:0]          last_read  = '0;   // byte of the last completed read
  logic                read_op    = 1'b0;
  logic                on_second  = 1'b0; // second byte of the transaction
  logic                pin_ce     = 1'b0;
  logic                pin_sclk   = 1'b0;
  logic                pin_sdat   = 1'b0;
  logic                pin_sdrv   = 1'b0;
  logic                done_flag  = 1'b0;
  logic [TpuWidth-1:0] unit_len   = TpuWidth'(1); // ticks per delay unit, mirrors the register

  result_t     expected_pins_q[$];
  int unsigned err_count      = 0;
  int unsigned ticks_sent     = 0;
  int unsigned send_gap_pct   = 8;
  int unsigned recv_stall_pct = 64;

  // Receiver hold-off request: the test flips hold_toggle, the stall
  // process acknowledges it and counts the hold itself.
  logic        hold_toggle = 1'b0;
  logic        hold_ack    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned quiet_cycles = 0;

  function automatic void begin_wait(input phase_e ph, input logic [3:0] n);
    seq_phase  = ph;
    units_left = n;
    unit_ticks = '0;
  endfunction

  // Take the data line, hold the clock low and wait one unit before a byte.
  function automatic void load_byte(input logic [7:0] value);
    tx_shift = value;
    bit_pos  = '0;
    pin_sdrv = 1'b1;
    pin_sclk = 1'b0;
    begin_wait(PH_WPRE, 4'd1);
  endfunction

  // Latch the data pin for the current read bit, then raise the clock.
  function automatic void sample_bit(input logic level);
    rx_shift[bit_pos[2:0]] = level;
    pin_sclk = 1'b1;
    begin_wait(PH_RHIGH, 4'd1);
  endfunction

  function automatic void end_transaction();
    pin_sclk   = 1'b1;
    pin_ce     = 1'b0;
    seq_phase  = PH_IDLE;
    units_left = '0;
    unit_ticks = '0;
    done_flag  = 1'b1;
  endfunction

  function automatic result_t predict_tick(input logic start, input opcode_e op,
                                           input logic [7:0] cmd, input logic [7:0] wdata,
                                           input logic level);
    logic [TpuWidth-1:0] len;
    logic                byte_done;
    result_t             r;
    len       = (unit_len == '0) ? TpuWidth'(1) : unit_len;  // a zero unit acts as one tick
    done_flag = 1'b0;
    byte_done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      // Latch the fields only on a start taken while idle.
      if (start) begin
        read_op   = (op == OP_READ);
        tx_shift  = cmd;
        data_byte = wdata;
        on_second = 1'b0;
        bit_pos   = '0;
        pin_ce    = 1'b1;
        pin_sclk  = 1'b0;
        if (!read_op && SETUP_UNITS != 0) begin
          begin_wait(PH_SETUP, SETUP_UNITS);
        end else begin
          load_byte(tx_shift);
        end
      end
    end else begin
      unit_ticks = unit_ticks + 12'd1;
      if (unit_ticks >= 12'(len)) begin
        unit_ticks = '0;
        if (units_left > 4'd1) begin
          units_left = units_left - 4'd1;
        end else begin
          case (seq_phase)
            PH_SETUP: load_byte(tx_shift);
            PH_WPRE, PH_WHIGH: begin
              if (seq_phase == PH_WHIGH) begin
                // Drop the clock and advance; after eight bits pick the next byte.
                pin_sclk = 1'b0;
                bit_pos  = bit_pos + 4'd1;
                if (bit_pos >= 4'd8) begin
                  bit_pos   = '0;
                  byte_done = 1'b1;
                  if (on_second) begin
                    end_transaction();
                  end else if (read_op) begin
                    on_second = 1'b1;
                    pin_sdrv  = 1'b0;
                    rx_shift  = '0;
                    begin_wait(PH_RPRE, 4'd1);
                  end else begin
                    on_second = 1'b1;
                    load_byte(data_byte);
                  end
                end
              end
              if (!byte_done) begin
                pin_sdat = tx_shift[bit_pos[2:0]];
                begin_wait(PH_WSET, 4'd1);
              end
            end
            PH_WSET: begin
              pin_sclk = 1'b1;
              begin_wait(PH_WHIGH, 4'd1);
            end
            PH_RPRE: sample_bit(level);
            PH_RHIGH: begin
              pin_sclk = 1'b0;
              begin_wait(PH_RLOW, 4'd1);
            end
            PH_RLOW: begin
              bit_pos = bit_pos + 4'd1;
              if (bit_pos >= 4'd8) begin
                bit_pos   = '0;
                last_read = rx_shift;
                end_transaction();
              end else begin
                sample_bit(level);
              end
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
    end
    r.chip_enable       = pin_ce;
    r.serial_clock      = pin_sclk;
    r.data_pin_out      = pin_sdat;
    r.data_drive_enable = pin_sdrv;
    r.busy              = (seq_phase != PH_IDLE);
    r.done              = done_flag;
    r.read_byte         = last_read;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one tick, after a random gap, and hold it until the block takes it.
  task automatic send_tick(input logic start, input opcode_e op, input logic [7:0] cmd,
                           input logic [7:0] wdata, input logic level);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_req_i   <= start;
    opcode_i      <= op;
    command_i     <= cmd;
    write_data_i  <= wdata;
    data_pin_in_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    expected_pins_q.push_back(predict_tick(start, op, cmd, wdata, level));
    ticks_sent++;
  endtask

  // Random fields; a start raised here is ignored while the sequencer is busy.
  task automatic send_random_tick(input logic level);
    send_tick(1'($urandom_range(1)), $urandom_range(1) ? OP_READ : OP_WRITE,
              8'($urandom_range(255)), 8'($urandom_range(255)), level);
  endtask

  // Start one transaction and clock it through to its done tick. With a
  // pattern the data pin returns pattern[bit]; otherwise it toggles at random.
  task automatic run_transaction(input opcode_e op, input logic [7:0] cmd,
                                 input logic [7:0] wdata, input logic use_pattern,
                                 input logic [7:0] pattern);
    send_tick(1'b1, op, cmd, wdata, 1'($urandom_range(1)));
    while (seq_phase != PH_IDLE) begin
      send_random_tick(use_pattern ? pattern[bit_pos[2:0]] : logic'($urandom_range(1)));
    end
  endtask

  // Finish any transaction, drain the output, then write the unit length.
  task automatic set_unit_len(input logic [TpuWidth-1:0] len);
    while (seq_phase != PH_IDLE) send_random_tick(1'($urandom_range(1)));
    in_valid_i <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= len;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    unit_len = len;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Stall at random, or hold off for a long stretch when asked.
  always @(posedge clk_i) begin
    if (hold_ack != hold_toggle) begin
      hold_ack    <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  result_t got_pins;
  result_t want_pins;

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_pins = {chip_enable_o, serial_clock_o, data_pin_out_o, data_drive_enable_o,
                  busy_res_o, done_res_o, read_byte_o};
      if (expected_pins_q.size() == 0) begin
        report_error("output transfer with nothing expected");
      end else begin
        want_pins = expected_pins_q.pop_front();
        if (got_pins.chip_enable !== want_pins.chip_enable)
          report_error($sformatf("chip_enable %b, expected %b",
                                 got_pins.chip_enable, want_pins.chip_enable));
        if (got_pins.serial_clock !== want_pins.serial_clock)
          report_error($sformatf("serial_clock %b, expected %b",
                                 got_pins.serial_clock, want_pins.serial_clock));
        if (got_pins.data_pin_out !== want_pins.data_pin_out)
          report_error($sformatf("data_pin_out %b, expected %b",
                                 got_pins.data_pin_out, want_pins.data_pin_out));
        if (got_pins.data_drive_enable !== want_pins.data_drive_enable)
          report_error($sformatf("data_drive_enable %b, expected %b",
                                 got_pins.data_drive_enable, want_pins.data_drive_enable));
        if (got_pins.busy !== want_pins.busy)
          report_error($sformatf("busy %b, expected %b", got_pins.busy, want_pins.busy));
        if (got_pins.done !== want_pins.done)
          report_error($sformatf("done %b, expected %b", got_pins.done, want_pins.done));
        if (got_pins.read_byte !== want_pins.read_byte)
          report_error($sformatf("read_byte %h, expected %h",
                                 got_pins.read_byte, want_pins.read_byte));
      end
    end
  end

  // Give up once neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("three_wire_rtc_serial_master_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle ticks right after reset: pins low, line released, read byte zero.
  task automatic test_reset_levels();
    repeat (3) send_tick(1'b0, OP_WRITE, 8'hFF, 8'hFF, 1'b1);
  endtask

  // Writes with the byte extremes, including the setup delay.
  task automatic test_write_extremes();
    run_transaction(OP_WRITE, 8'hFF, 8'h00, 1'b0, 8'h00);
    run_transaction(OP_WRITE, 8'h00, 8'hFF, 1'b0, 8'h00);
    run_transaction(OP_WRITE, 8'hA5, 8'h5A, 1'b0, 8'h00);
  endtask

  // Reads with fixed pin patterns so every bit of the read byte takes both values.
  task automatic test_read_patterns();
    run_transaction(OP_READ, 8'h81, 8'h00, 1'b1, 8'hFF);
    run_transaction(OP_READ, 8'h7E, 8'hFF, 1'b1, 8'h00);
    run_transaction(OP_READ, 8'hC3, 8'h3C, 1'b1, 8'h96);
  endtask

  // A zero unit length must behave as one tick per unit.
  task automatic test_zero_unit();
    set_unit_len('0);
    run_transaction(OP_WRITE, 8'h3C, 8'hC3, 1'b0, 8'h00);
    run_transaction(OP_READ, 8'h55, 8'hAA, 1'b1, 8'h69);
  endtask

  // Hold the receiver off while the sender keeps offering ticks.
  task automatic test_backpressure();
    set_unit_len(10'd2);
    hold_toggle <= ~hold_toggle;
    run_transaction(OP_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'b0, 8'h00);
    run_transaction(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'b0, 8'h00);
  endtask

  // Several ticks per unit: a single read, then back to the reset length.
  task automatic test_long_unit();
    set_unit_len(10'd5);
    run_transaction(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    1'b0, 8'h00);
    set_unit_len(10'd1);
  endtask

  // Mostly complete transactions with random content, some idle noise,
  // and an occasional change of the unit length between transactions.
  task automatic run_random_mix(input int unsigned items, input int unsigned gap_pct,
                                input int unsigned stall_pct);
    int unsigned         first;
    logic [TpuWidth-1:0] lens[5];
    lens           = '{10'd1, 10'd1, 10'd2, 10'd0, 10'd3};
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    first          = ticks_sent;
    while (ticks_sent - first < items) begin
      case ($urandom_range(9))
        0: set_unit_len(lens[3'($urandom_range(4))]);
        1: repeat ($urandom_range(1, 6)) begin
          send_tick(1'b0, $urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        default: run_transaction($urandom_range(1) ? OP_READ : OP_WRITE,
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 1'b0, 8'h00);
      endcase
    end
  endtask

  task automatic test_random();
    run_random_mix(410, 8, 64);
    run_random_mix(410, 64, 8);
    run_random_mix(410, 0, 0);
  endtask

  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("three_wire_rtc_serial_master_tb: clean");
    end else begin
      $display("three_wire_rtc_serial_master_tb: errors");
    end
    $finish;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_levels();
    test_write_extremes();
    test_read_patterns();
    test_zero_unit();
    test_backpressure();
    test_long_unit();
    test_random();
    finish_run();
  end

endmodule
